// ===== hw/rtl/ssdrv_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdrv_pkg
// Shared types, constants and segment tables for the seven-segment serial
// driver: operation codes, queue entry layout and the digit/symbol lookups.
// ----------------------------------------------------------------------------
package ssdrv_pkg;

    // Display and shift chain geometry
    localparam int NUM_DISPLAYS = 2;
    localparam int SHIFT_BITS   = 32;
    localparam int HALF_BITS    = SHIFT_BITS / 2;
    localparam int CNT_W        = $clog2(SHIFT_BITS);

    // Queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Limit register
    localparam logic [7:0] MAX_NUMBER_RESET = 8'd99;

    // Side codes
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    // Operation codes; the fourth code is unused and ignored
    typedef enum logic [1:0] {
        OP_NUMBER = 2'd0,
        OP_SYMBOL = 2'd1,
        OP_RAW    = 2'd2
    } op_t;

    // One classified update handed from front to back
    typedef struct packed {
        logic                 load;     // replace a half of the shadow
        logic                 side;     // which half
        logic [HALF_BITS-1:0] pattern;  // new segment bits for that half
    } queue_entry_t;

    // Result of a symbol table search
    typedef struct packed {
        logic       hit;
        logic [7:0] pat;
    } sym_lookup_t;

    // Segment pattern of one decimal digit
    function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h21;
            4'd1:    pat = 8'hF9;
            4'd2:    pat = 8'h13;
            4'd3:    pat = 8'h51;
            4'd4:    pat = 8'hC9;
            4'd5:    pat = 8'h45;
            4'd6:    pat = 8'h05;
            4'd7:    pat = 8'hF1;
            4'd8:    pat = 8'h01;
            4'd9:    pat = 8'hC1;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

    // Segment pattern of one symbol character, with a hit flag
    function automatic sym_lookup_t symbol_pattern(input logic [7:0] ch);
        sym_lookup_t res;
        res.hit = 1'b1;
        unique case (ch)
            8'h2D:   res.pat = 8'hDF;  // '-'
            8'h20:   res.pat = 8'hFF;  // ' '
            8'h53:   res.pat = 8'h45;  // 'S'
            8'h64:   res.pat = 8'h19;  // 'd'
            8'h45:   res.pat = 8'h07;  // 'E'
            8'h52:   res.pat = 8'h80;  // 'R'
            8'h41:   res.pat = 8'h80;  // 'A'
            8'h46:   res.pat = 8'h87;  // 'F'
            default:
            begin
                res.hit = 1'b0;
                res.pat = 8'h00;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/ssdrv_front.sv =====
// ----------------------------------------------------------------------------
// ssdrv_front
// Accepts operations, checks them against the limit register and the symbol
// table, builds the 16-bit half pattern and pushes it into the queue.
// ----------------------------------------------------------------------------
module ssdrv_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [7:0]              cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              opcode,
    input  logic                    side,
    input  logic [7:0]              number,
    input  logic [7:0]              char_first,
    input  logic [7:0]              char_second,
    input  logic [15:0]             raw_pattern,
    output logic                    push_valid,
    input  logic                    push_ready,
    output ssdrv_pkg::queue_entry_t push_entry
);
    import ssdrv_pkg::*;

    logic [7:0]  max_number_reg;
    logic        keep;
    logic [15:0] recip_prod;
    logic [4:0]  tens_full;
    logic [7:0]  tens_times_ten;
    logic [3:0]  tens_digit;
    logic [3:0]  ones_digit;
    logic        side_ok;
    sym_lookup_t sym_hi;
    sym_lookup_t sym_lo;

    // Hold the display limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_number_reg <= MAX_NUMBER_RESET;
        else if (cfg_wr_en)
            max_number_reg <= cfg_wr_data;
    end

    // Split the number into digits: n/10 as (n*205)>>11, exact below 1029
    assign recip_prod     = 16'(number) * 16'd205;
    assign tens_full      = recip_prod[15:11];
    assign tens_times_ten = 8'(tens_full) * 8'd10;
    assign ones_digit     = 4'(number - tens_times_ten);

    // Drop the hundreds digit
    always_comb
    begin
        priority if (tens_full >= 5'd20)
            tens_digit = 4'(tens_full - 5'd20);
        else if (tens_full >= 5'd10)
            tens_digit = 4'(tens_full - 5'd10);
        else
            tens_digit = 4'(tens_full);
    end

    assign side_ok = (32'(side) < NUM_DISPLAYS);
    assign sym_hi  = symbol_pattern(char_first);
    assign sym_lo  = symbol_pattern(char_second);

    // Classify the operation and build the queue entry
    always_comb
    begin
        keep               = 1'b0;
        push_entry.load    = 1'b0;
        push_entry.side    = side;
        push_entry.pattern = raw_pattern;
        unique case (opcode)
            OP_NUMBER:
            begin
                keep               = side_ok && (number <= max_number_reg);
                push_entry.load    = 1'b1;
                push_entry.pattern = {digit_pattern(tens_digit), digit_pattern(ones_digit)};
            end
            OP_SYMBOL:
            begin
                keep               = side_ok && sym_hi.hit && sym_lo.hit;
                push_entry.load    = 1'b1;
                push_entry.pattern = {sym_hi.pat, sym_lo.pat};
            end
            OP_RAW:
            begin
                // Out-of-range side still shifts the unchanged shadow out
                keep               = 1'b1;
                push_entry.load    = side_ok;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Take an item whenever the queue has room; dropped items vanish here
    assign in_ready   = push_ready;
    assign push_valid = in_valid && keep;

endmodule

// ===== hw/rtl/ssdrv_queue.sv =====
// ----------------------------------------------------------------------------
// ssdrv_queue
// Short FIFO of classified updates between the front and the shift-out back.
// ----------------------------------------------------------------------------
module ssdrv_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  ssdrv_pkg::queue_entry_t push_entry,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output ssdrv_pkg::queue_entry_t pop_entry
);
    import ssdrv_pkg::*;

    queue_entry_t      entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hw/rtl/ssdrv_back.sv =====
// ----------------------------------------------------------------------------
// ssdrv_back
// Applies queued updates to the shadow register and shifts all shadow bits
// out one per output transfer, least significant bit first.
// ----------------------------------------------------------------------------
module ssdrv_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  ssdrv_pkg::queue_entry_t pop_entry,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    serial_bit,
    output logic                    last_bit
);
    import ssdrv_pkg::*;

    logic [SHIFT_BITS-1:0] shadow_reg;
    logic [SHIFT_BITS-1:0] shadow_next;
    logic [SHIFT_BITS-1:0] shift_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  out_xfer;
    logic                  do_pop;

    assign out_valid  = busy_reg;
    assign serial_bit = shift_reg[0];
    assign last_bit   = busy_reg && (cnt_reg == CNT_W'(SHIFT_BITS - 1));
    assign out_xfer   = out_valid && out_ready;

    // Take the next update when idle or as the final bit leaves
    assign pop_ready  = !busy_reg || (out_xfer && last_bit);
    assign do_pop     = pop_valid && pop_ready;

    // Replace one half of the shadow
    always_comb
    begin
        shadow_next = shadow_reg;
        if (pop_entry.load)
        begin
            if (pop_entry.side == SIDE_RIGHT)
                shadow_next[HALF_BITS-1:0] = pop_entry.pattern;
            else
                shadow_next[SHIFT_BITS-1:HALF_BITS] = pop_entry.pattern;
        end
    end

    // Control and shadow state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= '0;
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (do_pop)
        begin
            shadow_reg <= shadow_next;
            busy_reg   <= 1'b1;
            cnt_reg    <= '0;
        end
        else if (out_xfer)
        begin
            if (last_bit)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Load or advance the shift register
    always_ff @(posedge clk)
    begin
        if (do_pop)
            shift_reg <= shadow_next;
        else if (out_xfer)
            shift_reg <= {1'b0, shift_reg[SHIFT_BITS-1:1]};
    end

endmodule

// ===== hw/rtl/seven_segment_serial_driver_unit.sv =====
// ----------------------------------------------------------------------------
// seven_segment_serial_driver_unit
// Top level: front classifier, update queue and shift-out back end.
// ----------------------------------------------------------------------------
// Each accepted operation that passes its checks produces a run of 32 output
// transfers, shadow bit 0 first, with last_bit marking the 32nd; the shift
// register in the back end moves one bit per cycle while out_ready is high.
// Rejected operations (number above max_number, unknown symbol, unused
// opcode) are taken whenever the queue has room and give no output. The
// front keeps accepting while the two-entry queue has room, so up to two
// updates can wait behind a run in progress. Write max_number only while the
// block is idle.
module seven_segment_serial_driver_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic        side,
    input  logic [7:0]  number,
    input  logic [7:0]  char_first,
    input  logic [7:0]  char_second,
    input  logic [15:0] raw_pattern,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        serial_bit,
    output logic        last_bit
);
    import ssdrv_pkg::*;

    logic         push_valid;
    logic         push_ready;
    queue_entry_t push_entry;
    logic         pop_valid;
    logic         pop_ready;
    queue_entry_t pop_entry;

    // Classify incoming operations
    ssdrv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .side        (side),
        .number      (number),
        .char_first  (char_first),
        .char_second (char_second),
        .raw_pattern (raw_pattern),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    // Buffer updates between the two sides
    ssdrv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // Apply updates and shift the shadow out
    ssdrv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .serial_bit (serial_bit),
        .last_bit   (last_bit)
    );

endmodule

// ===== hw/rtl/ssdrv_checker.sv =====
// ----------------------------------------------------------------------------
// ssdrv_checker
// Port-level checks on the output run framing of the serial driver, bound
// to the top level.
// ----------------------------------------------------------------------------
module ssdrv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        serial_bit,
    input logic        last_bit
);

    // Hold a stalled output transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(serial_bit) && $stable(last_bit))
        else $error("stalled output changed");

    // Keep a run going until its last bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_bit |=> out_valid)
        else $error("output run broke before last bit");

    // Start a new run away from the last bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_bit |=> !last_bit)
        else $error("back-to-back last bits");

    // Open every run on its first bit
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !last_bit)
        else $error("run opened on last bit");

endmodule

bind seven_segment_serial_driver_unit ssdrv_checker u_checker (.*);

// ===== dv/seven_segment_chain_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_chain_checker
// Watches the operation, limit and shift chain ports of the seven-segment
// serial driver. It keeps its own shadow of the 32 segment bits and the
// number limit, works out the bits each accepted operation shifts out, and
// compares every output transfer with the oldest expected bit.
// ----------------------------------------------------------------------------
module seven_segment_chain_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic        side,
    input  logic [7:0]  number,
    input  logic [7:0]  char_first,
    input  logic [7:0]  char_second,
    input  logic [15:0] raw_pattern,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        serial_bit,
    input  logic        last_bit,
    output int unsigned error_count,
    output int unsigned bits_pending
);
    import ssdrv_pkg::*;

    // Segment tables, entry 0 in the low byte
    localparam logic [79:0] DIGIT_SEGS  = {8'hC1, 8'h01, 8'hF1, 8'h05, 8'h45,
                                           8'hC9, 8'h51, 8'h13, 8'hF9, 8'h21};
    // Symbol characters: - space S d E R A F
    localparam logic [63:0] GLYPH_CODES = {8'h46, 8'h41, 8'h52, 8'h45,
                                           8'h64, 8'h53, 8'h20, 8'h2D};
    localparam logic [63:0] GLYPH_SEGS  = {8'h87, 8'h80, 8'h80, 8'h07,
                                           8'h19, 8'h45, 8'hFF, 8'hDF};

    typedef struct packed {
        logic serial;
        logic last;
    } chain_bit_t;

    chain_bit_t  chain_bits_due[$];
    logic [31:0] shadow_segs;
    logic [7:0]  number_limit;

    initial
    begin
        error_count  = 0;
        bits_pending = 0;
    end

    task automatic report_error(input string msg);
        $display("[%0t] chain mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Search the symbol table; the first matching entry wins
    task automatic lookup_glyph(input logic [7:0] ch, output logic hit,
                                output logic [7:0] segs);
        hit  = 1'b0;
        segs = 8'h00;
        for (int i = 7; i >= 0; i--)
        begin
            if (GLYPH_CODES[i*8 +: 8] == ch)
            begin
                hit  = 1'b1;
                segs = GLYPH_SEGS[i*8 +: 8];
            end
        end
    endtask

    // Apply one accepted operation to the shadow and queue its shifted bits
    task automatic predict_shift_out();
        logic [15:0] half_segs;
        logic        loads;
        logic        shifts;
        logic        hit_hi;
        logic        hit_lo;
        logic [7:0]  segs_hi;
        logic [7:0]  segs_lo;
        int          tens;
        int          ones;
        chain_bit_t  cb;

        half_segs = '0;
        loads     = 1'b0;
        shifts    = 1'b0;
        case (opcode)
            OP_NUMBER:
            begin
                if (number <= number_limit)
                begin
                    tens      = (number / 10) % 10;
                    ones      = number % 10;
                    half_segs = {DIGIT_SEGS[tens*8 +: 8], DIGIT_SEGS[ones*8 +: 8]};
                    loads     = 1'b1;
                    shifts    = 1'b1;
                end
            end
            OP_SYMBOL:
            begin
                lookup_glyph(char_first, hit_hi, segs_hi);
                lookup_glyph(char_second, hit_lo, segs_lo);
                if (hit_hi && hit_lo)
                begin
                    half_segs = {segs_hi, segs_lo};
                    loads     = 1'b1;
                    shifts    = 1'b1;
                end
            end
            OP_RAW:
            begin
                half_segs = raw_pattern;
                loads     = 1'b1;
                shifts    = 1'b1;
            end
            default:
            begin
                // unused code: drop the operation
            end
        endcase

        if (loads)
        begin
            if (side == SIDE_RIGHT)
                shadow_segs[15:0] = half_segs;
            else
                shadow_segs[31:16] = half_segs;
        end

        if (shifts)
        begin
            for (int k = 0; k < 32; k++)
            begin
                cb.serial = shadow_segs[k];
                cb.last   = (k == 31);
                chain_bits_due.push_back(cb);
            end
        end
    endtask

    // Compare one output transfer with the oldest expected bit
    task automatic check_chain_bit();
        chain_bit_t want;

        if (chain_bits_due.size() == 0)
        begin
            report_error($sformatf("unexpected transfer serial_bit=%0b last_bit=%0b",
                                   serial_bit, last_bit));
        end
        else
        begin
            want = chain_bits_due.pop_front();
            if (serial_bit !== want.serial)
                report_error($sformatf("serial_bit expected %0b, got %0b",
                                       want.serial, serial_bit));
            if (last_bit !== want.last)
                report_error($sformatf("last_bit expected %0b, got %0b",
                                       want.last, last_bit));
        end
    endtask

    // Track the block at every rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_segs  = '0;
            number_limit = MAX_NUMBER_RESET;
            chain_bits_due.delete();
            bits_pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_chain_bit();
            if (cfg_wr_en)
                number_limit = cfg_wr_data;
            if (in_valid && in_ready)
                predict_shift_out();
            bits_pending = chain_bits_due.size();
        end
    end

endmodule

// ===== dv/tb_seven_segment_serial_driver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_serial_driver_unit
// Drives number, symbol, raw and unused operations into the seven-segment
// serial driver under several number limits and idle patterns, while a
// checker beside the block predicts and compares every shifted bit.
// ----------------------------------------------------------------------------
module tb_seven_segment_serial_driver_unit;
    import ssdrv_pkg::*;

    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 40;
    // Symbol characters: - space S d E R A F
    localparam logic [63:0] GLYPH_CODES   = {8'h46, 8'h41, 8'h52, 8'h45,
                                             8'h64, 8'h53, 8'h20, 8'h2D};

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic        side;
    logic [7:0]  number;
    logic [7:0]  char_first;
    logic [7:0]  char_second;
    logic [15:0] raw_pattern;
    logic        out_valid;
    logic        out_ready;
    logic        serial_bit;
    logic        last_bit;

    int unsigned mismatch_count;
    int unsigned bits_pending;
    int unsigned cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic [7:0]  limit_setting;

    seven_segment_serial_driver_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .side        (side),
        .number      (number),
        .char_first  (char_first),
        .char_second (char_second),
        .raw_pattern (raw_pattern),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .serial_bit  (serial_bit),
        .last_bit    (last_bit)
    );

    seven_segment_chain_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .side         (side),
        .number       (number),
        .char_first   (char_first),
        .char_second  (char_second),
        .raw_pattern  (raw_pattern),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .serial_bit   (serial_bit),
        .last_bit     (last_bit),
        .error_count  (mismatch_count),
        .bits_pending (bits_pending)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the shift chain at random
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // End the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Present one operation and hold it until the transfer
    task automatic send_op(input logic [1:0] opc, input logic sd, input logic [7:0] num,
                           input logic [7:0] ch1, input logic [7:0] ch2,
                           input logic [15:0] raw);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        opcode      <= opc;
        side        <= sd;
        number      <= num;
        char_first  <= ch1;
        char_second <= ch2;
        raw_pattern <= raw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_glyph();
        int idx;
        idx = $urandom_range(0, 7);
        return GLYPH_CODES[idx*8 +: 8];
    endfunction

    // Mostly well-formed operations, some out of range or unknown
    task automatic send_random_op();
        int          pick;
        logic [1:0]  opc;
        logic [7:0]  num;
        logic [7:0]  ch1;
        logic [7:0]  ch2;

        pick = $urandom_range(0, 99);
        if (pick < 35)
            opc = OP_NUMBER;
        else if (pick < 65)
            opc = OP_SYMBOL;
        else if (pick < 90)
            opc = OP_RAW;
        else
            opc = OP_UNUSED;

        num = 8'($urandom_range(0, 255));
        if (opc == OP_NUMBER && $urandom_range(0, 4) != 0)
            num = 8'($urandom_range(0, limit_setting));

        ch1 = 8'($urandom_range(0, 255));
        ch2 = 8'($urandom_range(0, 255));
        if (opc == OP_SYMBOL)
        begin
            if ($urandom_range(0, 9) != 0)
                ch1 = pick_glyph();
            if ($urandom_range(0, 9) != 0)
                ch2 = pick_glyph();
        end

        send_op(opc, 1'($urandom_range(0, 1)), num, ch1, ch2,
                16'($urandom_range(0, 65535)));
    endtask

    // Drop valid and hold until every expected bit has shifted out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bits_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        @(negedge clk);
        cfg_wr_en     <= 1'b0;
        limit_setting = value;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        opcode        = OP_NUMBER;
        side          = SIDE_LEFT;
        number        = '0;
        char_first    = '0;
        char_second   = '0;
        raw_pattern   = '0;
        out_ready     = 1'b0;
        tx_idle_pct   = 30;
        rx_idle_pct   = 60;
        limit_setting = MAX_NUMBER_RESET;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed operations under the reset limit
        send_op(OP_NUMBER, SIDE_LEFT,  8'd0,   8'h00, 8'h00, 16'h0000);
        send_op(OP_NUMBER, SIDE_RIGHT, 8'd99,  8'h00, 8'h00, 16'h0000);
        send_op(OP_NUMBER, SIDE_LEFT,  8'd100, 8'h00, 8'h00, 16'h0000);
        send_op(OP_NUMBER, SIDE_RIGHT, 8'd255, 8'hFF, 8'hFF, 16'hFFFF);
        send_op(OP_NUMBER, SIDE_LEFT,  8'd57,  8'h00, 8'h00, 16'h0000);
        send_op(OP_SYMBOL, SIDE_LEFT,  8'd0,   8'h2D, 8'h20, 16'h0000);
        send_op(OP_SYMBOL, SIDE_RIGHT, 8'd0,   8'h53, 8'h64, 16'h0000);
        send_op(OP_SYMBOL, SIDE_LEFT,  8'd0,   8'h45, 8'h52, 16'h0000);
        send_op(OP_SYMBOL, SIDE_RIGHT, 8'd0,   8'h41, 8'h46, 16'h0000);
        // unknown first, then unknown second character
        send_op(OP_SYMBOL, SIDE_LEFT,  8'd0,   8'h78, 8'h53, 16'h0000);
        send_op(OP_SYMBOL, SIDE_RIGHT, 8'd0,   8'h53, 8'hFF, 16'h0000);
        send_op(OP_RAW,    SIDE_LEFT,  8'd0,   8'h00, 8'h00, 16'h0000);
        send_op(OP_RAW,    SIDE_RIGHT, 8'd0,   8'h00, 8'h00, 16'hFFFF);
        send_op(OP_RAW,    SIDE_LEFT,  8'hFF,  8'hFF, 8'hFF, 16'hA5A5);
        send_op(OP_RAW,    SIDE_RIGHT, 8'd0,   8'h00, 8'h00, 16'h5A5A);
        send_op(OP_UNUSED, SIDE_RIGHT, 8'hFF,  8'hFF, 8'hFF, 16'hFFFF);
        send_op(OP_RAW,    SIDE_LEFT,  8'd0,   8'h00, 8'h00, 16'hFFFF);

        // Open the limit fully; hundreds digit is dropped
        wait_idle();
        write_limit(8'd255);
        send_op(OP_NUMBER, SIDE_LEFT,  8'd255, 8'h00, 8'h00, 16'h0000);
        send_op(OP_NUMBER, SIDE_RIGHT, 8'd100, 8'h00, 8'h00, 16'h0000);
        send_op(OP_NUMBER, SIDE_LEFT,  8'd199, 8'h00, 8'h00, 16'h0000);
        repeat (60) send_random_op();

        // Tightest limit, idle pattern swapped
        wait_idle();
        write_limit(8'd0);
        tx_idle_pct = 60;
        rx_idle_pct = 30;
        repeat (60) send_random_op();

        // Random limit, no idling, one full drain in the middle
        wait_idle();
        write_limit(8'($urandom_range(1, 254)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (30) send_random_op();
        wait_idle();
        repeat (30) send_random_op();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && bits_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== seven_segment_serial_driver_unit.f =====
hw/rtl/ssdrv_pkg.sv
hw/rtl/ssdrv_front.sv
hw/rtl/ssdrv_queue.sv
hw/rtl/ssdrv_back.sv
hw/rtl/seven_segment_serial_driver_unit.sv
hw/rtl/ssdrv_checker.sv
dv/seven_segment_chain_checker.sv
dv/tb_seven_segment_serial_driver_unit.sv
